FILE: design/nrb_pkg.sv
// Shared constants, state encoding and status types for the n-th root bisection block.
package nrb_pkg;

  // Width of the exponent field of an input word.
  localparam int ExponentWidth = 6;

  // Multiplier bits consumed by the serial multiplier in each cycle.
  localparam int DigitBits = 8;

  // Search sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIFF   = 6'b000010,
    S_TEST   = 6'b000100,
    S_LAUNCH = 6'b001000,
    S_MUL    = 6'b010000,
    S_FINISH = 6'b100000
  } nrb_state_e;

  // Status returned by the serial multiplier.
  typedef struct packed {
    logic done;
    logic sat;
  } mul_stat_t;

endpackage

FILE: design/nrb_if.sv
// Valid/ready channel interfaces for the input and result words.
interface nrb_in_if #(
  parameter int RadicandBits = 16
);
  import nrb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ExponentWidth-1:0] exponent;
  logic [RadicandBits-1:0]  radicand;

  modport source (output valid, output exponent, output radicand, input ready);
  modport sink   (input valid, input exponent, input radicand, output ready);
endinterface

interface nrb_out_if #(
  parameter int RootWidth = 40
);
  logic                 valid;
  logic                 ready;
  logic [RootWidth-1:0] root_value;
  logic                 bad_input;

  modport source (output valid, output root_value, output bad_input, input ready);
  modport sink   (input valid, input root_value, input bad_input, output ready);
endinterface

FILE: design/nrb_mul.sv
// Digit-serial fixed-point multiplier with saturation test against a limit.
module nrb_mul import nrb_pkg::*; #(
  parameter int RootWidth    = 40,
  parameter int FractionBits = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RootWidth-1:0] mcand_i,
  input  logic [RootWidth-1:0] mplier_i,
  input  logic [RootWidth-1:0] limit_i,
  output mul_stat_t            stat_o,
  output logic [RootWidth-1:0] prod_o
);

  localparam int NumDigits = (RootWidth + DigitBits - 1) / DigitBits;
  localparam int XWidth    = NumDigits * DigitBits;
  localparam int PWidth    = RootWidth + XWidth;
  localparam int SWidth    = RootWidth + DigitBits;
  localparam int HWidth    = PWidth - FractionBits;
  localparam int CntWidth  = $clog2(NumDigits + 1);

  logic                busy_q, busy_d;
  logic                cmp_q, cmp_d;
  logic                done_q, done_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                sat_q;
  logic [RootWidth-1:0] a_q;
  logic [XWidth-1:0]   x_q;
  logic [PWidth-1:0]   prod_q;
  logic [RootWidth-1:0] q_q;
  logic [SWidth-1:0]   sum;
  logic [HWidth-1:0]   shifted;

  // One partial product per cycle is added into the top of the running product.
  assign sum = SWidth'(prod_q[PWidth-1:XWidth])
             + SWidth'(a_q) * SWidth'(x_q[DigitBits-1:0]);

  // Fixed-point rescale of the finished product.
  assign shifted = prod_q[PWidth-1:FractionBits];

  // Sequencing of the digit passes and the final compare.
  always_comb begin
    busy_d = busy_q;
    cmp_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CntWidth'(1);
      if (cnt_q == CntWidth'(NumDigits - 1)) begin
        busy_d = 1'b0;
        cmp_d  = 1'b1;
      end
    end else if (cmp_q) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cmp_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cmp_q  <= cmp_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand shift register, product accumulator and result.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= mcand_i;
      x_q    <= XWidth'(mplier_i);
      prod_q <= '0;
    end else if (busy_q) begin
      x_q    <= x_q >> DigitBits;
      prod_q <= {sum, prod_q[XWidth-1:DigitBits]};
    end
    if (cmp_q) begin
      sat_q <= shifted > HWidth'(limit_i);
      q_q   <= shifted[RootWidth-1:0];
    end
  end

  assign stat_o = '{done: done_q, sat: sat_q};
  assign prod_o = q_q;

endmodule

FILE: design/nth_root_bisection_top.sv
// Top level of the n-th root bisection block: search sequencer and result register.
//
// Each word gives an exponent n and a radicand m; the block returns the lower
// bound of a bisection over [1, m] in unsigned fixed point with FRACTION_BITS
// fraction bits, or bad_input with a zero root when n or m is zero. Exponents
// above EXPONENT_MAX are clamped. One word is worked on at a time. A bisection
// step does k multiplications, each over the D 8-bit digits of a
// RADICAND_BITS+FRACTION_BITS wide operand (5 at the default sizes), where k
// is the number of multiplications done before the power is known or
// saturates (at most n); there are up to about RADICAND_BITS+FRACTION_BITS
// steps. The rate is set by the shared multiplier, which consumes one 8-bit
// digit of the midpoint per cycle. A new word is accepted while the previous
// result still waits to be taken.
module nth_root_bisection_top import nrb_pkg::*; #(
  parameter int RADICAND_BITS = 16,
  parameter int FRACTION_BITS = 24,
  parameter int EXPONENT_MAX  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nrb_in_if.sink    in_i,
  nrb_out_if.source out_o
);

  localparam int RootWidth  = RADICAND_BITS + FRACTION_BITS;
  localparam int CountWidth = $clog2(EXPONENT_MAX + 1);
  localparam logic [RootWidth-1:0] One = RootWidth'(1) << FRACTION_BITS;

  nrb_state_e           state_q, state_d;
  logic [RootWidth-1:0] low_q, low_d;
  logic [RootWidth-1:0] high_q, high_d;
  logic [RootWidth-1:0] target_q, target_d;
  logic [RootWidth-1:0] mid_q, mid_d;
  logic [RootWidth-1:0] diff_q, diff_d;
  logic [RootWidth-1:0] pow_q, pow_d;
  logic [CountWidth-1:0] n_q, n_d;
  logic [CountWidth-1:0] left_q, left_d;
  logic                 bad_q, bad_d;
  logic                 out_valid_q, out_valid_d;
  logic [RootWidth-1:0] out_root_q;
  logic                 out_bad_q;
  logic                 load_out;
  logic                 mul_start;
  mul_stat_t            mul_stat;
  logic [RootWidth-1:0] mul_prod;

  // Shared serial multiplier.
  nrb_mul #(
    .RootWidth    (RootWidth),
    .FractionBits (FRACTION_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (pow_q),
    .mplier_i (mid_q),
    .limit_i  (target_q),
    .stat_o   (mul_stat),
    .prod_o   (mul_prod)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign load_out   = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);

  // Search sequencer.
  always_comb begin
    state_d   = state_q;
    low_d     = low_q;
    high_d    = high_q;
    target_d  = target_q;
    mid_d     = mid_q;
    diff_d    = diff_q;
    pow_d     = pow_q;
    n_d       = n_q;
    left_d    = left_q;
    bad_d     = bad_q;
    mul_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.exponent == '0 || in_i.radicand == '0) begin
            low_d   = '0;
            bad_d   = 1'b1;
            state_d = S_FINISH;
          end else begin
            target_d = RootWidth'(in_i.radicand) << FRACTION_BITS;
            high_d   = RootWidth'(in_i.radicand) << FRACTION_BITS;
            low_d    = One;
            bad_d    = 1'b0;
            if (32'(in_i.exponent) > 32'(EXPONENT_MAX)) begin
              n_d = CountWidth'(EXPONENT_MAX);
            end else begin
              n_d = CountWidth'(in_i.exponent);
            end
            state_d = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        diff_d  = high_q - low_q;
        state_d = S_TEST;
      end
      S_TEST: begin
        if (diff_q > RootWidth'(1)) begin
          mid_d   = low_q + (diff_q >> 1);
          pow_d   = One;
          left_d  = n_q;
          state_d = S_LAUNCH;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_LAUNCH: begin
        mul_start = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        if (mul_stat.done) begin
          if (mul_stat.sat) begin
            // The power has passed the radicand: the root lies below mid.
            high_d  = mid_q;
            state_d = S_DIFF;
          end else begin
            pow_d = mul_prod;
            if (left_q == CountWidth'(1)) begin
              if (mul_prod < target_q) begin
                low_d = mid_q;
              end else begin
                high_d = mid_q;
              end
              state_d = S_DIFF;
            end else begin
              left_d  = left_q - CountWidth'(1);
              state_d = S_LAUNCH;
            end
          end
        end
      end
      S_FINISH: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Search bounds and working values.
  always_ff @(posedge clk_i) begin
    low_q    <= low_d;
    high_q   <= high_d;
    target_q <= target_d;
    mid_q    <= mid_d;
    diff_q   <= diff_d;
    pow_q    <= pow_d;
    n_q      <= n_d;
    left_q   <= left_d;
    bad_q    <= bad_d;
    if (load_out) begin
      out_root_q <= low_q;
      out_bad_q  <= bad_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.root_value = out_root_q;
  assign out_o.bad_input  = out_bad_q;

  // The multiplier reports only while the sequencer waits for it.
  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> state_q == S_MUL)
    else $error("multiplier finished outside the multiply state");

  // The bounds never cross during a search.
  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIFF) |-> low_q <= high_q)
    else $error("bisection bounds crossed");

  // A multiplication is only pending while some remain.
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAUNCH || state_q == S_MUL) |-> left_q != '0)
    else $error("multiply counter ran out");

  // A flagged word carries a zero root.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> out_root_q == '0)
    else $error("bad input word with nonzero root");

endmodule
